[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QTN_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QTN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/qtn_pkg.sv]
// Types and fixed constants of the quadrature tone plus noise source.
package qtn_pkg;

  localparam int ReqTypeW = 1;
  localparam int IndexW   = 12;
  localparam int NoiseW   = 16;
  localparam int PhasorW  = 16;
  localparam int GainW    = 15;
  localparam int LenW     = 13;
  localparam int FracBits = 15;
  localparam int AddrW    = 4;

  typedef logic signed [NoiseW-1:0] q15_t;

  localparam logic [ReqTypeW-1:0] ReqTick  = 1'b0;
  localparam logic [ReqTypeW-1:0] ReqWrite = 1'b1;

  localparam logic [1:0] RegCosStep     = 2'd0;
  localparam logic [1:0] RegSinStep     = 2'd1;
  localparam logic [1:0] RegSignalGain  = 2'd2;
  localparam logic [1:0] RegNoiseLength = 2'd3;

  localparam q15_t              CosStepReset  = 16'sh7FFF;
  localparam q15_t              SinStepReset  = 16'sh0000;
  localparam logic [GainW-1:0]  GainReset     = 15'd0;
  localparam logic [LenW-1:0]   LengthReset   = 13'd4096;
  localparam q15_t              PhasorCosInit = 16'sh7FFF;
  localparam q15_t              PhasorSinInit = 16'sh0000;

endpackage

[rtl/qtn_if.sv]
// Valid/ready channel interfaces for the request and sample streams.
interface qtn_in_if import qtn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [IndexW-1:0]   noise_index;
  q15_t                noise_value;

  modport source (output valid, output req_type, output noise_index, output noise_value,
                  input ready);
  modport sink (input valid, input req_type, input noise_index, input noise_value,
                output ready);
endinterface

interface qtn_out_if #(parameter int SampleWidth = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] i_sample;
  logic signed [SampleWidth-1:0] q_sample;

  modport source (output valid, output i_sample, output q_sample, input ready);
  modport sink (input valid, input i_sample, input q_sample, output ready);
endinterface

[rtl/quadrature_tone_plus_noise_source_core.sv]
// Quadrature tone plus noise source: phasor rotation on one shared multiplier.
//
//   channel  direction  handshake           payload
//   in_i     sink       valid/ready         req_type, noise_index, noise_value
//   out_o    source     valid/ready         i_sample, q_sample
//   apb      slave      psel/penable/pready cos_step, sin_step, signal_gain, noise_length
//
// A noise write is taken by the transfer alone and produces nothing.
// A sample tick is taken by the transfer and then runs seven steps: four rotation
// products and two gain products on the single 16x16 multiplier, then one emit step.
// The emit step waits while the output register still holds an untaken sample.
// Reset returns the phasor, position and registers to their initial values; the
// noise table is not cleared.
module quadrature_tone_plus_noise_source_core
  import qtn_pkg::*;
#(
  parameter int NOISE_DEPTH  = 4096,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  qtn_in_if.sink              in_i,
  qtn_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int MemAw = $clog2(NOISE_DEPTH);
  localparam int AccW  = 33;
  localparam logic signed [AccW-1:0] SatHi = (33'sd1 <<< (SAMPLE_WIDTH - 1)) - 33'sd1;
  localparam logic signed [AccW-1:0] SatLo = -SatHi - 33'sd1;
  localparam logic signed [AccW-1:0] PhHi  = 33'sd32767;
  localparam logic signed [AccW-1:0] PhLo  = -33'sd32768;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRotCc = 3'd1;
  localparam logic [2:0] StRotSs = 3'd2;
  localparam logic [2:0] StRotCs = 3'd3;
  localparam logic [2:0] StRotSc = 3'd4;
  localparam logic [2:0] StToneI = 3'd5;
  localparam logic [2:0] StToneQ = 3'd6;
  localparam logic [2:0] StEmit  = 3'd7;

  logic [2:0]             state_q, state_d;
  q15_t                   cos_step_q, sin_step_q;
  logic [GainW-1:0]       gain_q;
  logic [LenW-1:0]        length_q;
  q15_t                   ph_cos_q, ph_sin_q;
  logic [MemAw-1:0]       pos_q;
  logic signed [AccW-1:0] acc_q;
  q15_t                   noise_i_q, noise_q_q, rd_q;
  logic signed [SAMPLE_WIDTH-1:0] i_res_q, i_out_q, q_out_q;
  logic                   out_valid_q;

  q15_t                   noise_mem [NOISE_DEPTH];

  logic                   cfg_wr, in_fire, emit;
  logic signed [15:0]     mul_a, mul_b;
  logic signed [31:0]     product;
  logic signed [AccW-1:0] acc_sh, tone_sum;
  q15_t                   acc_sat16;
  logic [31:0]            len_eff, pos_inc, pos_nxt1, wr_idx;
  logic [MemAw-1:0]       rd_addr;
  logic                   rd_en;
  logic signed [SAMPLE_WIDTH-1:0] tone_sat;

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(input logic signed [AccW-1:0] x);
    logic signed [SAMPLE_WIDTH-1:0] r;
    if (x > SatHi) begin
      r = SatHi[SAMPLE_WIDTH-1:0];
    end else if (x < SatLo) begin
      r = SatLo[SAMPLE_WIDTH-1:0];
    end else begin
      r = x[SAMPLE_WIDTH-1:0];
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      RegCosStep:     prdata = {16'd0, cos_step_q};
      RegSinStep:     prdata = {16'd0, sin_step_q};
      RegSignalGain:  prdata = {17'd0, gain_q};
      RegNoiseLength: prdata = {19'd0, length_q};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_step_q <= CosStepReset;
      sin_step_q <= SinStepReset;
      gain_q     <= GainReset;
      length_q   <= LengthReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegCosStep:     cos_step_q <= pwdata[15:0];
        RegSinStep:     sin_step_q <= pwdata[15:0];
        RegSignalGain:  gain_q     <= pwdata[GainW-1:0];
        RegNoiseLength: length_q   <= pwdata[LenW-1:0];
        default:        ;
      endcase
    end
  end

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign wr_idx     = 32'(in_i.noise_index);

  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.req_type == ReqWrite && wr_idx < NOISE_DEPTH) begin
      noise_mem[wr_idx[MemAw-1:0]] <= in_i.noise_value;
    end
    if (rd_en) begin
      rd_q <= noise_mem[rd_addr];
    end
  end

  assign pos_nxt1 = 32'(pos_q) + 32'd1;
  assign rd_en    = (state_q == StRotCc) || (state_q == StRotSs);
  assign rd_addr  = (state_q == StRotSs) ?
                    ((pos_nxt1 == NOISE_DEPTH) ? '0 : pos_nxt1[MemAw-1:0]) : pos_q;

  always_comb begin
    case (state_q)
      StRotCc: begin mul_a = ph_cos_q; mul_b = cos_step_q; end
      StRotSs: begin mul_a = ph_sin_q; mul_b = sin_step_q; end
      StRotCs: begin mul_a = ph_cos_q; mul_b = sin_step_q; end
      StRotSc: begin mul_a = ph_sin_q; mul_b = cos_step_q; end
      StToneI: begin mul_a = ph_cos_q; mul_b = {1'b0, gain_q}; end
      StToneQ: begin mul_a = ph_sin_q; mul_b = {1'b0, gain_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign product = mul_a * mul_b;
  assign acc_sh  = acc_q >>> FracBits;

  always_comb begin
    if (acc_sh > PhHi) begin
      acc_sat16 = PhHi[15:0];
    end else if (acc_sh < PhLo) begin
      acc_sat16 = PhLo[15:0];
    end else begin
      acc_sat16 = acc_sh[15:0];
    end
  end

  assign tone_sum = AccW'((state_q == StEmit) ? noise_q_q : noise_i_q) + acc_sh;
  assign tone_sat = sat_out(tone_sum);
  assign emit     = (state_q == StEmit) && (!out_valid_q || out_o.ready);

  always_comb begin
    len_eff = 32'(length_q);
    if (len_eff < 32'd2) begin
      len_eff = 32'd2;
    end else if (len_eff > NOISE_DEPTH) begin
      len_eff = NOISE_DEPTH;
    end
  end
  assign pos_inc = 32'(pos_q) + 32'd2;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_fire && in_i.req_type == ReqTick) state_d = StRotCc;
      StRotCc: state_d = StRotSs;
      StRotSs: state_d = StRotCs;
      StRotCs: state_d = StRotSc;
      StRotSc: state_d = StToneI;
      StToneI: state_d = StToneQ;
      StToneQ: state_d = StEmit;
      StEmit:  if (emit) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ph_cos_q    <= PhasorCosInit;
      ph_sin_q    <= PhasorSinInit;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StRotCs) begin
        ph_cos_q <= acc_sat16;
      end
      if (state_q == StToneI) begin
        ph_sin_q <= acc_sat16;
      end
      if (emit) begin
        pos_q <= (pos_inc >= len_eff) ? '0 : pos_inc[MemAw-1:0];
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StRotCc, StRotCs, StToneI, StToneQ: acc_q <= AccW'(product);
      StRotSs: acc_q <= acc_q - AccW'(product);
      StRotSc: acc_q <= acc_q + AccW'(product);
      default: ;
    endcase
    if (state_q == StRotSs) begin
      noise_i_q <= rd_q;
    end
    if (state_q == StRotCs) begin
      noise_q_q <= rd_q;
    end
    if (state_q == StToneQ) begin
      i_res_q <= tone_sat;
    end
    if (emit) begin
      i_out_q <= i_res_q;
      q_out_q <= tone_sat;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.i_sample = i_out_q;
  assign out_o.q_sample = q_out_q;

endmodule

[rtl/qtn_checker.sv]
// Port-level checker for the quadrature tone plus noise source, with its bind.
`include "assert_macros.svh"

module qtn_checker
  import qtn_pkg::*;
#(
  parameter int SampleWidth = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [ReqTypeW-1:0]           in_req_type_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [SampleWidth-1:0] out_i_sample_i,
  input logic signed [SampleWidth-1:0] out_q_sample_i
);

  logic in_tick, out_stall;

  assign in_tick   = in_valid_i && in_ready_i && (in_req_type_i == ReqTick);
  assign out_stall = out_valid_i && !out_ready_i;

  `QTN_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_stall, out_valid_i)
  `QTN_ASSERT_NEXT(a_out_i_holds, clk_i, rst_ni, out_stall, $stable(out_i_sample_i))
  `QTN_ASSERT_NEXT(a_out_q_holds, clk_i, rst_ni, out_stall, $stable(out_q_sample_i))
  `QTN_ASSERT_NEXT(a_busy_after_tick, clk_i, rst_ni, in_tick, !in_ready_i)
  `QTN_ASSERT_SAME(a_no_instant_result, clk_i, rst_ni, $rose(out_valid_i), !$past(in_tick))

endmodule

bind quadrature_tone_plus_noise_source_core qtn_checker #(
  .SampleWidth(SAMPLE_WIDTH)
) u_qtn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_req_type_i (in_i.req_type),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_i_sample_i(out_o.i_sample),
  .out_q_sample_i(out_o.q_sample)
);
